@@ sv/pwra_pkg.sv @@
package pwra_pkg;

    localparam int SAMPLE_W = 16;

    // configuration register indexes
    localparam logic REG_SPLIT  = 1'b0;
    localparam logic REG_WINDOW = 1'b1;

    // front-to-back work descriptor
    typedef struct packed {
        logic                       drop;
        logic                       side_act;
        logic                       inner;
        logic [31:0]                pos;
        logic signed [SAMPLE_W-1:0] sample;
        logic [31:0]                cnt_all;
        logic [31:0]                cnt_side;
    } t_work;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_OUT   = 6'b010000,
        ST_CLR   = 6'b100000
    } t_state;

endpackage

@@ sv/pulse_waveform_running_average.sv @@
// Point-by-point running average of pulses. For each sample the back end runs
// one serial 64-step divider once for the all-pulse bank and, for a split pulse,
// once more for the side bank; a dropped sample skips the divider, and any
// output stall holds the back end. A single-entry front register lets the next
// sample be classified meanwhile. After reset a clearing pass zeroes the banks;
// the front register can take one sample, then the input stalls until it is done.
module pulse_waveform_running_average #(
    parameter int POINTS     = 1024,
    parameter int COUNT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [15:0]   i_sample_value,
    input  logic signed [15:0]   i_time_of_flight,
    input  logic                 i_first_of_pulse,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [9:0]           o_point_index,
    output logic signed [23:0]   o_mean_all,
    output logic signed [23:0]   o_mean_side,
    output logic                 o_side_inner,
    output logic                 o_dropped,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    logic            r_split;
    logic [15:0]     r_window;
    logic            w_wv, w_ws;
    pwra_pkg::t_work w_work;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split <= 1'b1;
            r_window <= 16'd256;
        end else if (i_cfg_we) begin
            if (i_cfg_index == pwra_pkg::REG_SPLIT) r_split <= i_cfg_data[0];
            else r_window <= i_cfg_data;
        end
    end

    pwra_front #(.POINTS(POINTS), .COUNT_BITS(COUNT_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_sample_value(i_sample_value), .i_time_of_flight(i_time_of_flight),
        .i_first_of_pulse(i_first_of_pulse), .i_split(r_split), .i_window(r_window),
        .o_wvalid(w_wv), .i_wstall(w_ws), .o_work(w_work)
    );

    pwra_back #(.POINTS(POINTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wvalid(w_wv), .o_wstall(w_ws),
        .i_work(w_work), .o_valid(o_valid), .i_stall(i_stall),
        .o_point_index(o_point_index), .o_mean_all(o_mean_all),
        .o_mean_side(o_mean_side), .o_side_inner(o_side_inner), .o_dropped(o_dropped)
    );

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped) |-> (o_mean_all == 24'sd0 && !o_side_inner))
        else $error("dropped result carries data");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_mean_all)))
        else $error("stalled result changed");
endmodule

@@ sv/pwra_divider.sv @@
// signed restoring divider, one quotient bit per cycle, truncates toward zero
module pwra_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic [31:0]        i_den,
    output logic               o_done,
    output logic signed [63:0] o_quot
);
    logic [63:0] r_q, n_q;
    logic [64:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [64:0] w_sh;

    always_comb begin
        w_sh  = {r_rem[63:0], r_q[63]};
        n_q   = {r_q[62:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {33'd0, r_den}) begin
            n_rem = w_sh - {33'd0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_neg  <= i_num[63];
                r_q    <= i_num[63] ? 64'(-i_num) : i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

@@ sv/pwra_front.sv @@
// classifies samples, tracks counts and position, issues work descriptors
module pwra_front #(
    parameter int POINTS     = 1024,
    parameter int COUNT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [15:0]   i_sample_value,
    input  logic signed [15:0]   i_time_of_flight,
    input  logic                 i_first_of_pulse,
    input  logic                 i_split,
    input  logic [15:0]          i_window,
    output logic                 o_wvalid,
    input  logic                 i_wstall,
    output pwra_pkg::t_work      o_work
);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam int PW = $clog2(POINTS + 1);

    logic [COUNT_BITS-1:0] r_ca, r_ci, r_co, n_ca, n_ci, n_co;
    logic [PW-1:0]         r_pos, n_pos, w_idx;
    logic                  r_inner, r_act, n_inner, n_act;
    logic                  r_v;
    pwra_pkg::t_work       r_w, n_w;
    logic [16:0]           w_mag;
    logic                  w_acc;

    assign o_stall = r_v && i_wstall;
    assign o_wvalid = r_v;
    assign o_work = r_w;
    assign w_acc = i_valid && !o_stall;

    always_comb begin
        n_ca = r_ca; n_ci = r_ci; n_co = r_co;
        n_inner = r_inner; n_act = r_act;
        w_idx = r_pos;
        w_mag = i_time_of_flight[15] ? 17'(-$signed({i_time_of_flight[15], i_time_of_flight}))
                                     : 17'({1'b0, i_time_of_flight});
        if (i_first_of_pulse) begin
            w_idx = '0;
            if (r_ca != CMAX) n_ca = r_ca + 1'b1;
            n_act = i_split;
            n_inner = i_split && (w_mag <= {1'b0, i_window});
            if (i_split) begin
                if (n_inner) begin
                    if (r_ci != CMAX) n_ci = r_ci + 1'b1;
                end else if (r_co != CMAX) n_co = r_co + 1'b1;
            end
        end
        n_pos = (32'(w_idx) >= POINTS) ? w_idx : w_idx + 1'b1;
        n_w.drop = 32'(w_idx) >= POINTS;
        n_w.side_act = n_act;
        n_w.inner = n_inner;
        n_w.pos = 32'(w_idx);
        n_w.sample = i_sample_value;
        n_w.cnt_all = 32'(n_ca);
        n_w.cnt_side = n_inner ? 32'(n_ci) : 32'(n_co);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ca <= '0; r_ci <= '0; r_co <= '0; r_pos <= '0;
            r_inner <= 1'b0; r_act <= 1'b0; r_v <= 1'b0;
        end else begin
            r_v <= w_acc || (r_v && i_wstall);
            if (w_acc) begin
                r_ca <= n_ca; r_ci <= n_ci; r_co <= n_co; r_pos <= n_pos;
                r_inner <= n_inner; r_act <= n_act;
                r_w <= n_w;
            end
        end
    end
endmodule

@@ sv/pwra_back.sv @@
// bank update engine: clear after reset, then read, multiply-accumulate, divide, write, emit
module pwra_back #(
    parameter int POINTS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wvalid,
    output logic                 o_wstall,
    input  pwra_pkg::t_work      i_work,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [9:0]           o_point_index,
    output logic signed [23:0]   o_mean_all,
    output logic signed [23:0]   o_mean_side,
    output logic                 o_side_inner,
    output logic                 o_dropped
);
    localparam int AW = $clog2(POINTS);

    logic signed [23:0] r_ma [POINTS];
    logic signed [23:0] r_mi [POINTS];
    logic signed [23:0] r_mo [POINTS];

    pwra_pkg::t_state   r_st;
    pwra_pkg::t_work    r_w;
    logic signed [23:0] r_rd_a, r_rd_s, r_new_a, r_new_s;
    logic               r_phase;
    logic signed [63:0] r_num;
    logic               r_start;
    logic               w_done;
    logic signed [63:0] w_quot;
    logic [AW-1:0]      w_a;
    logic signed [23:0] w_old;
    logic [31:0]        w_n;
    logic               r_ov;
    logic               w_emit;
    logic [AW-1:0]      r_clr;

    assign w_a = r_w.pos[AW-1:0];
    assign o_wstall = (r_st != pwra_pkg::ST_IDLE);
    assign o_valid = r_ov;
    assign w_old = r_phase ? r_rd_s : r_rd_a;
    assign w_n = r_phase ? r_w.cnt_side : r_w.cnt_all;
    assign w_emit = (r_st == pwra_pkg::ST_OUT) && (!r_ov || !i_stall);

    pwra_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_num(r_num), .i_den(w_n), .o_done(w_done), .o_quot(w_quot)
    );

    // memory reads
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_ma[w_a];
        r_rd_s <= r_w.inner ? r_mi[w_a] : r_mo[w_a];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= pwra_pkg::ST_CLR;
            r_clr <= '0;
            r_ov <= 1'b0; r_start <= 1'b0;
        end else begin
            r_start <= (r_st == pwra_pkg::ST_MUL) && (w_n != 32'd0);
            r_ov <= w_emit || (r_ov && i_stall);
            case (r_st)
                pwra_pkg::ST_CLR: begin
                    r_ma[r_clr] <= '0;
                    r_mi[r_clr] <= '0;
                    r_mo[r_clr] <= '0;
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(POINTS - 1)) r_st <= pwra_pkg::ST_IDLE;
                end
                pwra_pkg::ST_IDLE: begin
                    if (i_wvalid) begin
                        r_w <= i_work;
                        r_phase <= 1'b0;
                        r_st <= pwra_pkg::ST_READ;
                    end
                end
                pwra_pkg::ST_READ: begin
                    if (r_w.drop) r_st <= pwra_pkg::ST_OUT;
                    else r_st <= pwra_pkg::ST_MUL;
                end
                pwra_pkg::ST_MUL: begin
                    r_num <= 64'($signed({1'b0, w_n - 32'd1}) * w_old)
                             + (64'(r_w.sample) <<< 8);
                    r_st <= pwra_pkg::ST_DIV;
                end
                pwra_pkg::ST_DIV: begin
                    if (w_n == 32'd0 || w_done) begin
                        if (!r_phase) begin
                            r_new_a <= (w_n == 32'd0) ? w_old : w_quot[23:0];
                            if (w_n != 32'd0) r_ma[w_a] <= w_quot[23:0];
                            if (r_w.side_act) begin
                                r_phase <= 1'b1;
                                r_st <= pwra_pkg::ST_MUL;
                            end else begin
                                r_new_s <= 24'sd0;
                                r_st <= pwra_pkg::ST_OUT;
                            end
                        end else begin
                            r_new_s <= (w_n == 32'd0) ? w_old : w_quot[23:0];
                            if (w_n != 32'd0) begin
                                if (r_w.inner) r_mi[w_a] <= w_quot[23:0];
                                else r_mo[w_a] <= w_quot[23:0];
                            end
                            r_st <= pwra_pkg::ST_OUT;
                        end
                    end
                end
                pwra_pkg::ST_OUT: begin
                    if (w_emit) begin
                        o_dropped <= r_w.drop;
                        o_point_index <= r_w.drop ? 10'd0 : r_w.pos[9:0];
                        o_mean_all <= r_w.drop ? 24'sd0 : r_new_a;
                        o_mean_side <= (r_w.drop || !r_w.side_act) ? 24'sd0 : r_new_s;
                        o_side_inner <= !r_w.drop && r_w.side_act && r_w.inner;
                        r_st <= pwra_pkg::ST_IDLE;
                    end
                end
                default: r_st <= pwra_pkg::ST_IDLE;
            endcase
        end
    end
endmodule
